@@ rtl/core/page_frame_allocator_core_assert.svh @@
// Assertion macros for the page frame allocator core.
`ifndef PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PFA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define PFA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PFA_ASSERT(lbl, cond, msg)
`define PFA_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/pfa_pkg.sv @@
// Types and constants of the page frame allocator core.
package pfa_pkg;
    localparam int unsigned MAX_PAGES    = 4096;
    localparam int unsigned PAGE_W       = 12;
    localparam int unsigned CNT_W        = 13;
    localparam int unsigned TOP_RESERVED = 16;
    localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(MAX_PAGES);

    typedef enum logic [2:0] {
        OP_INIT       = 3'd0,
        OP_ALLOC_KERN = 3'd1,
        OP_ALLOC_USER = 3'd2,
        OP_ALLOC_PT   = 3'd3,
        OP_FREE       = 3'd4,
        OP_QUERY      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_OOM     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_TOTAL    = 3'd0,
        CFG_RESERVED = 3'd1,
        CFG_WIN_BASE = 3'd2,
        CFG_WIN_END  = 3'd3,
        CFG_POOL     = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_TAKE,
        S_REB_RD,
        S_REB_CHK,
        S_FREE_CHK,
        S_QRY_CHK,
        S_INIT,
        S_RESP
    } t_state;
endpackage

@@ rtl/core/page_frame_allocator_core.sv @@
// Page frame allocator: bitmap plus linked free lists, one result beat per request beat.
// Allocation and owner bits live in a 4096 x 2 bitmap RAM and the free-list links in a
// 4096 x 13 link RAM, both with a registered read port. A free, a query, or a pop from
// the general or page-table list head steps through read, update and response; a rejected
// request goes straight to the response. A bitmap scan reads and checks each page visited,
// taking a run writes its pages one by one, and the list rebuild after a multi-page
// run reads and checks every window page. Init sweeps every page once and then responds.
// A new request is taken while the previous result still waits in the output register.
`include "page_frame_allocator_core_assert.svh"
module page_frame_allocator_core
    import pfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // op[2:0], page_number[14:3], page_count[27:15]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // status[1:0], first_page[13:2], alloc_flag[14],
                                     // is_user[15], free_count[28:16]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    t_state r_state, n_state;

    logic [CNT_W-1:0] r_cfg_total, r_cfg_res, r_cfg_wb, r_cfg_we, r_cfg_pool;
    logic [CNT_W-1:0] r_total, n_total, r_base, n_base, r_end, n_end;
    logic [CNT_W-1:0] r_re, n_re, r_top_lo, n_top_lo;
    logic             r_top_en, n_top_en;
    logic [CNT_W-1:0] r_pool_first, n_pool_first, r_pool_last, n_pool_last;
    logic [CNT_W-1:0] r_gh, n_gh, r_ph, n_ph, r_free, n_free;
    logic [CNT_W-1:0] r_p, n_p, r_run, n_run, r_left, n_left, r_cnt, n_cnt;
    logic             r_user, n_user, r_pool_pop, n_pool_pop, r_rebuild, n_rebuild;
    logic [PAGE_W-1:0] r_pn, n_pn, r_first, n_first;
    t_status          r_status, n_status;
    logic             r_qa, n_qa, r_qu, n_qu;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_data, n_out_data;

    logic              bit_we, link_we;
    logic [PAGE_W-1:0] bit_waddr, bit_raddr, link_waddr, link_raddr;
    logic [1:0]        bit_wdata, bit_rdata;      // {alloc, owner}
    logic [CNT_W-1:0]  link_wdata, link_rdata;

    // init geometry from the configuration registers
    logic [CNT_W-1:0] g_t, g_we, g_wb, g_re, g_wp, g_s;
    logic [CNT_W:0]   g_sum;
    logic             g_pool_ok;

    logic [2:0]        in_op;
    logic [PAGE_W-1:0] in_pn;
    logic [CNT_W-1:0]  in_cnt;
    logic              s_acc;

    assign in_op  = i_s_tdata[2:0];
    assign in_pn  = i_s_tdata[14:3];
    assign in_cnt = i_s_tdata[27:15];
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign g_t  = (r_cfg_total > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : r_cfg_total;
    assign g_we = (r_cfg_we > g_t) ? g_t : r_cfg_we;
    assign g_wb = (r_cfg_wb > g_we) ? g_we : r_cfg_wb;
    assign g_re = (r_cfg_res < g_t) ? r_cfg_res : g_t;
    assign g_wp = g_we - g_wb;
    assign g_sum = {1'b0, r_cfg_pool} + (CNT_W+1)'(TOP_RESERVED);
    assign g_s  = g_we - g_sum[CNT_W-1:0];
    assign g_pool_ok = ({1'b0, g_wp} > g_sum) && (g_s > r_cfg_res);

    function automatic logic in_win(input logic [CNT_W-1:0] x,
                                    input logic [CNT_W-1:0] b,
                                    input logic [CNT_W-1:0] e);
        return (x >= b) && (x < e);
    endfunction

    function automatic logic in_pool(input logic [CNT_W-1:0] x,
                                     input logic [CNT_W-1:0] f,
                                     input logic [CNT_W-1:0] l);
        return (f != '0) && (l != '0) && (x >= f) && (x < l);
    endfunction

    pfa_ram #(.WIDTH(2), .DEPTH(MAX_PAGES)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bit_we),
        .i_waddr (bit_waddr),
        .i_wdata (bit_wdata),
        .i_raddr (bit_raddr),
        .o_rdata (bit_rdata)
    );

    pfa_ram #(.WIDTH(CNT_W), .DEPTH(MAX_PAGES)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    always_comb begin
        logic             sgl_go, sgl_user, init_set;
        logic [CNT_W-1:0] run_nx, start;
        n_state = r_state;
        n_total = r_total; n_base = r_base; n_end = r_end;
        n_re = r_re; n_top_lo = r_top_lo; n_top_en = r_top_en;
        n_pool_first = r_pool_first; n_pool_last = r_pool_last;
        n_gh = r_gh; n_ph = r_ph; n_free = r_free;
        n_p = r_p; n_run = r_run; n_left = r_left; n_cnt = r_cnt;
        n_user = r_user; n_pool_pop = r_pool_pop; n_rebuild = r_rebuild;
        n_pn = r_pn; n_first = r_first; n_status = r_status;
        n_qa = r_qa; n_qu = r_qu;
        n_out_valid = r_out_valid; n_out_data = r_out_data;
        bit_we = 1'b0; bit_waddr = r_p[PAGE_W-1:0]; bit_wdata = '0;
        bit_raddr = r_p[PAGE_W-1:0];
        link_we = 1'b0; link_waddr = r_p[PAGE_W-1:0]; link_wdata = r_gh;
        link_raddr = '0;
        sgl_go = 1'b0; sgl_user = 1'b0; init_set = 1'b0;
        run_nx = '0; start = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_status = STAT_OK; n_first = '0; n_qa = 1'b0; n_qu = 1'b0;
                    n_pn = in_pn;
                    n_state = S_RESP;
                    unique case (in_op)
                        OP_INIT: begin
                            n_total = g_t; n_base = g_wb; n_end = g_we; n_re = g_re;
                            n_top_en = g_t > CNT_W'(TOP_RESERVED);
                            n_top_lo = g_t - CNT_W'(TOP_RESERVED);
                            n_pool_first = g_pool_ok ? g_s : '0;
                            n_pool_last  = g_pool_ok ? (g_s + r_cfg_pool) : '0;
                            n_free = g_t;
                            n_gh = EMPTY_MARK; n_ph = EMPTY_MARK;
                            n_p = '0;
                            n_state = S_INIT;
                        end
                        OP_ALLOC_KERN, OP_ALLOC_USER: begin
                            if (in_cnt == '0 || in_cnt > r_total) begin
                                n_status = STAT_INVALID;
                            end else if (in_cnt == CNT_W'(1)) begin
                                sgl_go = 1'b1;
                                sgl_user = (in_op == OP_ALLOC_USER);
                            end else begin
                                n_user = (in_op == OP_ALLOC_USER);
                                n_cnt = in_cnt; n_rebuild = 1'b1;
                                n_p = r_base; n_run = '0;
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_ALLOC_PT: begin
                            if (in_pool(r_pool_first, r_pool_first, r_pool_last) &&
                                in_win(r_ph, r_base, r_end)) begin
                                n_user = 1'b0; n_pool_pop = 1'b1;
                                n_pn = r_ph[PAGE_W-1:0];
                                link_raddr = r_ph[PAGE_W-1:0];
                                bit_raddr = r_ph[PAGE_W-1:0];
                                n_state = S_POP;
                            end else begin
                                sgl_go = 1'b1;
                            end
                        end
                        OP_FREE: begin
                            if ({1'b0, in_pn} >= r_total || {1'b0, in_pn} < r_base) begin
                                n_status = STAT_INVALID;
                            end else begin
                                bit_raddr = in_pn;
                                n_state = S_FREE_CHK;
                            end
                        end
                        OP_QUERY: begin
                            if ({1'b0, in_pn} >= r_total) begin
                                n_status = STAT_INVALID;
                            end else begin
                                bit_raddr = in_pn;
                                n_state = S_QRY_CHK;
                            end
                        end
                        default: n_status = STAT_INVALID;
                    endcase
                    if (sgl_go) begin
                        n_user = sgl_user;
                        if (in_win(r_gh, r_base, r_end)) begin
                            n_pool_pop = 1'b0;
                            n_pn = r_gh[PAGE_W-1:0];
                            link_raddr = r_gh[PAGE_W-1:0];
                            bit_raddr = r_gh[PAGE_W-1:0];
                            n_state = S_POP;
                        end else begin
                            n_cnt = CNT_W'(1); n_rebuild = 1'b0;
                            n_p = r_base; n_run = '0;
                            n_state = S_SCAN_RD;
                        end
                    end
                end
            end
            S_POP: begin
                if (r_pool_pop) begin
                    n_ph = link_rdata;
                end else begin
                    n_gh = link_rdata;
                end
                bit_we = 1'b1; bit_waddr = r_pn; bit_wdata = {1'b1, r_user};
                if (!bit_rdata[1] && r_free != '0) begin
                    n_free = r_free - 1'b1;
                end
                n_first = r_pn;
                n_state = S_RESP;
            end
            S_SCAN_RD: begin
                if (r_p >= r_end) begin
                    n_status = STAT_OOM;
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                run_nx = bit_rdata[1] ? '0 : r_run + 1'b1;
                start = r_p + 1'b1 - r_cnt;
                if (run_nx == r_cnt) begin
                    n_p = start; n_left = r_cnt;
                    n_first = start[PAGE_W-1:0];
                    n_state = S_TAKE;
                end else begin
                    n_p = r_p + 1'b1; n_run = run_nx;
                    n_state = S_SCAN_RD;
                end
            end
            S_TAKE: begin
                // every page of the found run is clear
                bit_we = 1'b1; bit_wdata = {1'b1, r_user};
                if (r_free != '0) begin
                    n_free = r_free - 1'b1;
                end
                n_p = r_p + 1'b1; n_left = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    if (r_rebuild) begin
                        n_gh = EMPTY_MARK; n_ph = EMPTY_MARK;
                        n_p = r_base;
                        n_state = S_REB_RD;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_REB_RD: begin
                n_state = (r_p >= r_end) ? S_RESP : S_REB_CHK;
            end
            S_REB_CHK: begin
                if (!bit_rdata[1]) begin
                    link_we = 1'b1;
                    if (in_pool(r_p, r_pool_first, r_pool_last)) begin
                        link_wdata = r_ph; n_ph = r_p;
                    end else begin
                        link_wdata = r_gh; n_gh = r_p;
                    end
                end
                n_p = r_p + 1'b1;
                n_state = S_REB_RD;
            end
            S_FREE_CHK: begin
                if (bit_rdata[1]) begin
                    bit_we = 1'b1; bit_waddr = r_pn; bit_wdata = {1'b0, bit_rdata[0]};
                    n_free = r_free + 1'b1;
                    link_we = 1'b1; link_waddr = r_pn;
                    if (in_pool({1'b0, r_pn}, r_pool_first, r_pool_last)) begin
                        link_wdata = r_ph; n_ph = {1'b0, r_pn};
                    end else begin
                        link_wdata = r_gh; n_gh = {1'b0, r_pn};
                    end
                end
                n_state = S_RESP;
            end
            S_QRY_CHK: begin
                n_qa = bit_rdata[1]; n_qu = bit_rdata[0];
                n_state = S_RESP;
            end
            S_INIT: begin
                init_set = (r_p < r_re) ||
                           (r_top_en && r_p >= r_top_lo && r_p < r_total);
                bit_we = 1'b1; bit_wdata = {init_set, 1'b0};
                if (init_set) begin
                    n_free = r_free - 1'b1;
                end else if (in_win(r_p, r_base, r_end)) begin
                    link_we = 1'b1;
                    if (in_pool(r_p, r_pool_first, r_pool_last)) begin
                        link_wdata = r_ph; n_ph = r_p;
                    end else begin
                        link_wdata = r_gh; n_gh = r_p;
                    end
                end
                n_p = r_p + 1'b1;
                if (r_p[PAGE_W-1:0] == PAGE_W'(MAX_PAGES - 1)) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data = {3'b000, r_free, r_qu, r_qa, r_first, r_status};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg_total <= CNT_W'(MAX_PAGES);
            r_cfg_res <= '0;
            r_cfg_wb <= '0;
            r_cfg_we <= CNT_W'(MAX_PAGES);
            r_cfg_pool <= '0;
            r_total <= '0; r_base <= '0; r_end <= '0;
            r_re <= '0; r_top_lo <= '0; r_top_en <= 1'b0;
            r_pool_first <= '0; r_pool_last <= '0;
            r_gh <= EMPTY_MARK; r_ph <= EMPTY_MARK; r_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TOTAL:    r_cfg_total <= i_cfg_data;
                    CFG_RESERVED: r_cfg_res <= i_cfg_data;
                    CFG_WIN_BASE: r_cfg_wb <= i_cfg_data;
                    CFG_WIN_END:  r_cfg_we <= i_cfg_data;
                    CFG_POOL:     r_cfg_pool <= i_cfg_data;
                    default: ;
                endcase
            end
            r_total <= n_total; r_base <= n_base; r_end <= n_end;
            r_re <= n_re; r_top_lo <= n_top_lo; r_top_en <= n_top_en;
            r_pool_first <= n_pool_first; r_pool_last <= n_pool_last;
            r_gh <= n_gh; r_ph <= n_ph; r_free <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_p <= n_p; r_run <= n_run; r_left <= n_left; r_cnt <= n_cnt;
        r_user <= n_user; r_pool_pop <= n_pool_pop; r_rebuild <= n_rebuild;
        r_pn <= n_pn; r_first <= n_first; r_status <= n_status;
        r_qa <= n_qa; r_qu <= n_qu;
        r_out_data <= n_out_data;
    end

    `PFA_ASSERT(a_free_le_total, r_free <= r_total, "free count exceeds managed pages")
    `PFA_ASSERT_IMPL(a_pool_order, r_pool_first != '0, r_pool_last >= r_pool_first, "bad pool")
    `PFA_ASSERT_IMPL(a_out_src, $rose(o_m_tvalid), $past(r_state == S_RESP), "stray beat")
endmodule

@@ rtl/core/pfa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pfa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ tb/sv/page_frame_allocator_core_test.sv @@
// Self-checking stream testbench for the page frame allocator core.
module page_frame_allocator_core_test;
    import pfa_pkg::*;

    localparam int LIMIT_CYCLES = 40000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    page_frame_allocator_core dut (.*);

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] first_page;
        logic        alloc_flag;
        logic        is_user;
        logic [12:0] free_count;
    } t_answer;

    int fail_count = 0;
    longint cycle_count = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    // Shadow allocator state and answer queue.
    class allocator_scoreboard;
        logic [12:0] cfg_regs[5];
        bit          alloc_map[MAX_PAGES];
        bit          owner_map[MAX_PAGES];
        logic [12:0] link_mem[MAX_PAGES];
        int unsigned gen_head, pt_head, free_pages, pool_lo, pool_hi;
        int unsigned total, win_lo, win_hi;
        t_answer     answers[$];

        function void clear();
            cfg_regs = '{13'd4096, 13'd0, 13'd0, 13'd4096, 13'd0};
            foreach (alloc_map[i]) begin
                alloc_map[i] = 0;
                owner_map[i] = 0;
                link_mem[i] = '0;
            end
            gen_head = MAX_PAGES;
            pt_head = MAX_PAGES;
            free_pages = 0;
            pool_lo = 0;
            pool_hi = 0;
            total = 0;
            win_lo = 0;
            win_hi = 0;
        endfunction

        function bit in_win(int unsigned p);
            return p >= win_lo && p < win_hi;
        endfunction

        function bit in_pool(int unsigned p);
            return pool_lo != 0 && pool_hi != 0 && p >= pool_lo && p < pool_hi;
        endfunction

        function void grab(int unsigned p, bit user);
            if (p >= MAX_PAGES) return;
            if (!alloc_map[p]) begin
                alloc_map[p] = 1;
                if (free_pages > 0) free_pages--;
            end
            owner_map[p] = user;
        endfunction

        function void push(int unsigned p);
            if (p >= MAX_PAGES) return;
            if (in_pool(p)) begin
                link_mem[p] = 13'(pt_head);
                pt_head = p;
            end else begin
                link_mem[p] = 13'(gen_head);
                gen_head = p;
            end
        endfunction

        function void relink();
            gen_head = MAX_PAGES;
            pt_head = MAX_PAGES;
            for (int unsigned p = win_lo; p < win_hi; p++)
                if (!alloc_map[p]) push(p);
        endfunction

        function bit take_one(bit user, output int unsigned pg);
            pg = 0;
            if (in_win(gen_head)) begin
                pg = gen_head;
                gen_head = link_mem[pg];
                grab(pg, user);
                return 1;
            end
            for (int unsigned p = win_lo; p < win_hi; p++)
                if (!alloc_map[p]) begin
                    grab(p, user);
                    pg = p;
                    return 1;
                end
            return 0;
        endfunction

        function bit take_run(bit user, int unsigned cnt, output int unsigned pg);
            int unsigned run;
            run = 0;
            pg = 0;
            for (int unsigned p = win_lo; p < win_hi; p++) begin
                run = alloc_map[p] ? 0 : run + 1;
                if (run == cnt) begin
                    pg = p + 1 - cnt;
                    for (int unsigned j = 0; j < cnt; j++) grab(pg + j, user);
                    relink();
                    return 1;
                end
            end
            return 0;
        endfunction

        function void rebuild();
            int unsigned t, res, wb, we, ps, re, s;
            t = cfg_regs[CFG_TOTAL];
            res = cfg_regs[CFG_RESERVED];
            wb = cfg_regs[CFG_WIN_BASE];
            we = cfg_regs[CFG_WIN_END];
            ps = cfg_regs[CFG_POOL];
            if (t > MAX_PAGES) t = MAX_PAGES;
            if (we > t) we = t;
            if (wb > we) wb = we;
            total = t;
            win_lo = wb;
            win_hi = we;
            foreach (alloc_map[i]) begin
                alloc_map[i] = 0;
                owner_map[i] = 0;
            end
            free_pages = t;
            re = res < t ? res : t;
            for (int unsigned p = 0; p < re; p++) grab(p, 0);
            pool_lo = 0;
            pool_hi = 0;
            if (we - wb > ps + TOP_RESERVED) begin
                s = we - ps - TOP_RESERVED;
                if (s > res) begin
                    pool_lo = s;
                    pool_hi = s + ps;
                end
            end
            if (t > TOP_RESERVED)
                for (int unsigned p = t - TOP_RESERVED; p < t; p++) grab(p, 0);
            relink();
        endfunction

        function void note_request(logic [31:0] beat);
            t_answer a;
            logic [2:0] op;
            int unsigned pn, cnt, pg;
            bit ok;
            op = beat[2:0];
            pn = beat[14:3];
            cnt = beat[27:15];
            a = '0;
            a.status = STAT_OK;
            case (op)
                OP_INIT: rebuild();
                OP_ALLOC_KERN, OP_ALLOC_USER: begin
                    if (cnt == 0 || cnt > total) a.status = STAT_INVALID;
                    else begin
                        ok = (cnt == 1) ? take_one(op == OP_ALLOC_USER, pg)
                                        : take_run(op == OP_ALLOC_USER, cnt, pg);
                        if (ok) a.first_page = 12'(pg);
                        else a.status = STAT_OOM;
                    end
                end
                OP_ALLOC_PT: begin
                    if (pool_lo != 0 && pool_hi != 0 && in_win(pt_head)) begin
                        pg = pt_head;
                        pt_head = link_mem[pg];
                        grab(pg, 0);
                        a.first_page = 12'(pg);
                    end else if (take_one(0, pg)) a.first_page = 12'(pg);
                    else a.status = STAT_OOM;
                end
                OP_FREE: begin
                    if (pn >= total || pn < win_lo) a.status = STAT_INVALID;
                    else if (alloc_map[pn]) begin
                        alloc_map[pn] = 0;
                        free_pages++;
                        push(pn);
                    end
                end
                OP_QUERY: begin
                    if (pn >= total) a.status = STAT_INVALID;
                    else begin
                        a.alloc_flag = alloc_map[pn];
                        a.is_user = owner_map[pn];
                    end
                end
                default: a.status = STAT_INVALID;
            endcase
            a.free_count = 13'(free_pages);
            answers.push_back(a);
        endfunction

        task check_answer(logic [31:0] beat);
            t_answer w;
            if (answers.size() == 0) begin
                report("unexpected beat", beat, 0);
                return;
            end
            w = answers.pop_front();
            if (beat[1:0] !== w.status) report("status", beat[1:0], w.status);
            if (beat[13:2] !== w.first_page) report("first_page", beat[13:2], w.first_page);
            if (beat[14] !== w.alloc_flag) report("alloc_flag", beat[14], w.alloc_flag);
            if (beat[15] !== w.is_user) report("is_user", beat[15], w.is_user);
            if (beat[28:16] !== w.free_count) report("free_count", beat[28:16], w.free_count);
        endtask
    endclass

    allocator_scoreboard sb;
    int stall_mode = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL page_frame_allocator_core");
            $finish;
        end
    end

    // Sample results and drive the receiver stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_answer(o_m_tdata);
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(3) != 0);
            default: i_m_tready <= (cycle_count % 7) < 3;
        endcase
        if ($urandom_range(199) == 0) stall_mode <= $urandom_range(2);
    end

    task automatic send(input logic [2:0] op, input logic [11:0] pn, input logic [12:0] cnt);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {4'b0, cnt, pn, op};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request({4'b0, cnt, pn, op});
    endtask

    task automatic idle(input int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.cfg_regs[idx] = val;
    endtask

    task automatic setup(input logic [12:0] t, input logic [12:0] res, input logic [12:0] wb,
                         input logic [12:0] we, input logic [12:0] ps);
        drain();
        write_cfg(CFG_TOTAL, t);
        write_cfg(CFG_RESERVED, res);
        write_cfg(CFG_WIN_BASE, wb);
        write_cfg(CFG_WIN_END, we);
        write_cfg(CFG_POOL, ps);
        send(OP_INIT, '0, '0);
    endtask

    // Mostly small runs, rarely large; any run over one page rebuilds.
    function automatic logic [12:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 13'd1;
        if (r < 85) return 13'($urandom_range(2, 8));
        if (r < 95) return '0;
        return 13'($urandom_range(8191));
    endfunction

    task automatic random_phase(input int n);
        int burst;
        logic [11:0] pn;
        int r;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                r = $urandom_range(99);
                pn = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(300));
                if (r < 30) send(OP_ALLOC_KERN, 12'($urandom), pick_count());
                else if (r < 45) send(OP_ALLOC_USER, 12'($urandom), pick_count());
                else if (r < 60) send(OP_ALLOC_PT, pn, 13'($urandom));
                else if (r < 82) send(OP_FREE, pn, 13'($urandom));
                else if (r < 97) send(OP_QUERY, pn, 13'($urandom));
                else if (r < 98) send(OP_INIT, pn, 13'($urandom));
                else send(3'($urandom_range(6, 7)), pn, 13'($urandom));
                burst--;
                n--;
            end
            if ($urandom_range(2) != 0) idle($urandom_range(1, 6));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TOTAL;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: before any init nothing is managed.
        send(OP_QUERY, 12'd0, '0);
        send(OP_ALLOC_KERN, '0, 13'd1);
        send(OP_ALLOC_PT, '0, '0);
        send(OP_FREE, 12'd4095, '0);
        send(3'd6, '0, '0);
        send(3'd7, 12'hFFF, 13'h1FFF);
        send(OP_INIT, '0, '0);
        send(OP_ALLOC_USER, '0, 13'd0);
        send(OP_ALLOC_USER, '0, 13'd4097);
        send(OP_ALLOC_USER, '0, 13'd3);
        send(OP_QUERY, 12'd1, '0);
        send(OP_ALLOC_KERN, '0, 13'd1);
        send(OP_FREE, 12'd4090, '0);
        send(OP_FREE, 12'd100, '0);
        send(OP_QUERY, 12'd4095, '0);
        send(OP_ALLOC_KERN, '0, 13'd4096);
        setup(13'd64, 13'd4, 13'd2, 13'd60, 13'd8);
        send(OP_ALLOC_PT, '0, '0);
        send(OP_ALLOC_PT, '0, '0);
        send(OP_FREE, 12'd1, '0);
        send(OP_FREE, 12'd3, '0);
        send(OP_ALLOC_KERN, '0, 13'd1);
        send(OP_QUERY, 12'd63, '0);
        send(OP_QUERY, 12'd64, '0);

        setup(13'd300, 13'd20, 13'd10, 13'd290, 13'd32);
        random_phase(350);
        setup(13'd8191, 13'd8191, 13'd8191, 13'd8191, 13'd8191);
        random_phase(40);
        setup(13'd16, 13'd0, 13'd0, 13'd16, 13'd0);
        random_phase(60);
        setup(13'd200, 13'd0, 13'd150, 13'd100, 13'd0);
        random_phase(60);
        setup(13'd128, 13'd0, 13'd0, 13'd128, 13'd4);
        random_phase(300);
        drain();
        setup(13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
        random_phase(40);
        setup(13'd4096, 13'd3000, 13'd2900, 13'd3200, 13'd50);
        random_phase(250);
        setup(13'd4096, 13'd0, 13'd0, 13'd4096, 13'd0);
        random_phase(120);
        drain();

        if (fail_count == 0)
            $display("PASS page_frame_allocator_core");
        else
            $display("FAIL page_frame_allocator_core");
        $finish;
    end
endmodule
